>>> rtl/register_mask_save_restore_assert.svh
// ---------------------------------------------------------------------------
// Register mask save/restore assertion macros
// Shared property forms used by the interface checker.
// ---------------------------------------------------------------------------
`ifndef REGISTER_MASK_SAVE_RESTORE_ASSERT_SVH
`define REGISTER_MASK_SAVE_RESTORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMSR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmsr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RMSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmsr: next-cycle check failed");

// The consequent must hold in the cycle after reset is sampled high.
`define RMSR_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("rmsr: post-reset check failed");

`endif

>>> rtl/rmsr_pkg.sv
// ---------------------------------------------------------------------------
// Register mask save/restore package
// Payload types and action codes shared by the channels and the block.
// ---------------------------------------------------------------------------
`default_nettype none

package rmsr_pkg;

   typedef logic [2:0]  action_type;
   typedef logic [4:0]  reg_index_type;
   typedef logic [9:0]  mem_index_type;
   typedef logic [63:0] word_type;
   typedef logic [31:0] mask_type;
   typedef logic [2:0]  mode_type;
   typedef logic [3:0]  base_reg_type;

   localparam int unsigned MEM_INDEX_W = 10;
   localparam int unsigned WORD_W      = 64;
   localparam int unsigned REG_TOTAL   = 32;

   localparam action_type ACT_WRITE_REG = 3'd0;
   localparam action_type ACT_READ_REG  = 3'd1;
   localparam action_type ACT_WRITE_MEM = 3'd2;
   localparam action_type ACT_READ_MEM  = 3'd3;
   localparam action_type ACT_SAVE      = 3'd4;
   localparam action_type ACT_RESTORE   = 3'd5;

   localparam word_type PTR_STEP = 64'd8;

endpackage

`default_nettype wire

>>> rtl/rmsr_req_if.sv
// ---------------------------------------------------------------------------
// Register mask save/restore request channel
// Valid/ready channel that carries one action transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface rmsr_req_if;
   import rmsr_pkg::*;

   logic          valid;
   logic          ready;
   action_type    action;
   reg_index_type reg_index;
   mem_index_type mem_index;
   word_type      value;
   mask_type      mask;
   mode_type      mode;
   base_reg_type  base_reg;

   modport source (
      output valid, action, reg_index, mem_index, value, mask, mode, base_reg,
      input  ready
   );

   modport sink (
      input  valid, action, reg_index, mem_index, value, mask, mode, base_reg,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/rmsr_rsp_if.sv
// ---------------------------------------------------------------------------
// Register mask save/restore response channel
// Valid/ready channel that carries one result transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface rmsr_rsp_if;
   import rmsr_pkg::*;

   logic     valid;
   logic     ready;
   word_type read_data;
   logic     status;
   word_type pointer_after;

   modport source (
      output valid, read_data, status, pointer_after,
      input  ready
   );

   modport sink (
      input  valid, read_data, status, pointer_after,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/rmsr_ram.sv
// ---------------------------------------------------------------------------
// Register mask save/restore RAM
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rmsr_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

>>> rtl/register_mask_save_restore.sv
// ---------------------------------------------------------------------------
// Register mask save/restore
// Register file with stack memory and mask-driven multiple save/restore.
// ---------------------------------------------------------------------------
// The block takes one transaction on the req_ channel and answers with one
// transaction on the rsp_ channel. It is busy from acceptance until the
// response is taken, so req_ready is high only while idle.
// Register and memory writes and register reads go from the execute state to
// the response; a memory read first passes a RAM read state. A save or
// restore with a valid mode passes a set-up state, a scan of every mask
// position through the single memory port, a drain state that finishes the
// last restore load and a write-back state for the final pointer. An invalid
// mode goes straight to the response with status set.
// The response is held in output registers until rsp_ready is seen; a stalled
// receiver keeps the block busy and holds the response stable.
// Reset clears all 32 registers and the sequencer; the stack memory is not
// cleared. MEM_DEPTH must be a power of two, and the word index is taken from
// the low bits of the pointer above the byte offset.
// ---------------------------------------------------------------------------
`default_nettype none

module register_mask_save_restore #(
   parameter int unsigned MEM_DEPTH = 1024
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rmsr_req_if.sink    req_if,
   rmsr_rsp_if.source  rsp_if
);
   import rmsr_pkg::*;

   localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_MRD   = 3'd2;
   localparam logic [2:0] ST_XFER  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_WB    = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [4:0]    step_ff, step_in;
   word_type      ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   reg_index_type pend_sel_ff, pend_sel_in;

   action_type    action_ff;
   reg_index_type reg_index_ff;
   mem_index_type mem_index_ff;
   word_type      value_ff;
   mask_type      mask_ff;
   mode_type      mode_ff;
   base_reg_type  base_ff;

   word_type      rd_ff, rd_in;
   logic          status_ff, status_in;
   word_type      ptr_out_ff, ptr_out_in;

   word_type      regs_ff [REG_TOTAL];
   logic          reg_we;
   reg_index_type reg_wsel;
   word_type      reg_wdata;
   reg_index_type rd_sel;
   word_type      reg_rdata;

   logic              ram_en, ram_we;
   logic [MEM_AW-1:0] ram_addr;
   word_type          ram_wdata, ram_rdata;

   logic              req_fire;
   logic              is_save, is_move;
   reg_index_type     xfer_sel;
   logic              xfer_bit;
   word_type          ptr_step, xfer_ptr;
   logic [MEM_AW-1:0] xfer_word, single_word;
   word_type          midx_ext;

   assign req_fire = req_if.valid && req_if.ready;
   assign is_save  = (action_ff == ACT_SAVE);
   assign is_move  = (action_ff == ACT_SAVE) || (action_ff == ACT_RESTORE);

   // Save scans general then float, each from 15 down; restore scans float then
   // general, each from 0 up.
   assign xfer_sel = is_save ? {step_ff[4], ~step_ff[3:0]} : {~step_ff[4], step_ff[3:0]};
   assign xfer_bit = mask_ff[xfer_sel];

   assign ptr_step  = mode_ff[0] ? (ptr_ff - PTR_STEP) : (ptr_ff + PTR_STEP);
   assign xfer_ptr  = mode_ff[1] ? ptr_step : ptr_ff;
   assign xfer_word = xfer_ptr[MEM_AW+2:3];

   assign midx_ext    = {{(WORD_W - MEM_INDEX_W){1'b0}}, mem_index_ff};
   assign single_word = midx_ext[MEM_AW-1:0];

   assign rd_sel    = (state_ff == ST_EXEC) ?
                      (is_move ? {1'b0, base_ff} : reg_index_ff) : xfer_sel;
   assign reg_rdata = regs_ff[rd_sel];

   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = single_word;
      ram_wdata = value_ff;
      if (state_ff == ST_EXEC) begin
         if (action_ff == ACT_WRITE_MEM) begin
            ram_en = 1'b1;
            ram_we = 1'b1;
         end else if (action_ff == ACT_READ_MEM) begin
            ram_en = 1'b1;
         end
      end else if ((state_ff == ST_XFER) && xfer_bit) begin
         ram_en    = 1'b1;
         ram_we    = is_save;
         ram_addr  = xfer_word;
         ram_wdata = reg_rdata;
      end
   end

   always_comb begin
      reg_we    = 1'b0;
      reg_wsel  = reg_index_ff;
      reg_wdata = value_ff;
      priority if (pend_ff) begin
         reg_we    = 1'b1;
         reg_wsel  = pend_sel_ff;
         reg_wdata = ram_rdata;
      end else if (state_ff == ST_WB) begin
         reg_we    = 1'b1;
         reg_wsel  = {1'b0, base_ff};
         reg_wdata = ptr_ff;
      end else if ((state_ff == ST_EXEC) && (action_ff == ACT_WRITE_REG)) begin
         reg_we = 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      ptr_in      = ptr_ff;
      pend_in     = 1'b0;
      pend_sel_in = xfer_sel;
      rd_in       = rd_ff;
      status_in   = status_ff;
      ptr_out_in  = ptr_out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rd_in      = '0;
            status_in  = 1'b0;
            ptr_out_in = '0;
            state_in   = ST_RESP;
            if (action_ff == ACT_READ_REG) begin
               rd_in = reg_rdata;
            end else if (action_ff == ACT_READ_MEM) begin
               state_in = ST_MRD;
            end else if (is_move) begin
               if (mode_ff[2]) begin
                  status_in = 1'b1;
               end else begin
                  ptr_in   = reg_rdata;
                  step_in  = '0;
                  state_in = ST_XFER;
               end
            end
         end
         ST_MRD: begin
            rd_in    = ram_rdata;
            state_in = ST_RESP;
         end
         ST_XFER: begin
            pend_in = xfer_bit && !is_save;
            if (xfer_bit) begin
               ptr_in = ptr_step;
            end
            step_in = step_ff + 5'd1;
            if (&step_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            ptr_out_in = ptr_ff;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      ptr_ff      <= ptr_in;
      pend_sel_ff <= pend_sel_in;
      rd_ff       <= rd_in;
      status_ff   <= status_in;
      ptr_out_ff  <= ptr_out_in;
      if (req_fire) begin
         action_ff    <= req_if.action;
         reg_index_ff <= req_if.reg_index;
         mem_index_ff <= req_if.mem_index;
         value_ff     <= req_if.value;
         mask_ff      <= req_if.mask;
         mode_ff      <= req_if.mode;
         base_ff      <= req_if.base_reg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_TOTAL; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (reg_we) begin
         regs_ff[reg_wsel] <= reg_wdata;
      end
   end

   rmsr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = (state_ff == ST_RESP);
   assign rsp_if.read_data     = rd_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.pointer_after = ptr_out_ff;
endmodule

`default_nettype wire

>>> rtl/rmsr_checker.sv
// ---------------------------------------------------------------------------
// Register mask save/restore checker
// Port-level checks of the request/response sequencing, bound to the block.
// ---------------------------------------------------------------------------
`default_nettype none

`include "register_mask_save_restore_assert.svh"

module rmsr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_status,
   input wire logic [63:0] rsp_read_data,
   input wire logic [63:0] rsp_pointer_after
);
   `RMSR_ASSERT_RESET(a_reset_no_rsp, clock, reset, !rsp_valid)
   `RMSR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `RMSR_ASSERT_SAME(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   `RMSR_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RMSR_ASSERT_SAME(a_bad_mode_zero, clock, reset, rsp_valid && rsp_status,
                     (rsp_read_data == 64'd0) && (rsp_pointer_after == 64'd0))
endmodule

bind register_mask_save_restore rmsr_checker u_rmsr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_read_data     (rsp_if.read_data),
   .rsp_pointer_after (rsp_if.pointer_after)
);

`default_nettype wire

>>> sim/tb_register_mask_save_restore.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Register mask save/restore testbench
// Drives register, memory, save-multiple and restore-multiple transactions
// through the request channel. An internal model of the register files and
// the stack memory predicts the responses that the directed table does not
// give; every response is checked field by field on the response channel.
// A short directed table comes first, followed by random save/restore
// sequences mixed with single accesses and noise, under bursty request
// traffic and an independently stalling receiver.

module tb_register_mask_save_restore;
   import rmsr_pkg::*;

   localparam int unsigned MEM_DEPTH    = 1024;
   localparam int unsigned DIR_ROWS     = 27;
   localparam int unsigned RANDOM_ITEMS = 450;
   localparam int unsigned HOLD_AT      = DIR_ROWS + 80;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned PAUSE_AT     = DIR_ROWS + 220;
   localparam int unsigned SETTLE       = 80;

   localparam mode_type MODE_POST_INC = 3'd0;
   localparam mode_type MODE_POST_DEC = 3'd1;
   localparam mode_type MODE_PRE_INC  = 3'd2;
   localparam mode_type MODE_PRE_DEC  = 3'd3;
   localparam mode_type MODE_BAD_LO   = 3'd4;
   localparam mode_type MODE_BAD_HI   = 3'd7;

   localparam action_type ACT_UNDEF_LO = 3'd6;
   localparam action_type ACT_UNDEF_HI = 3'd7;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_MODE = 1'b1;

   localparam word_type ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      action_type    action;
      reg_index_type reg_index;
      mem_index_type mem_index;
      word_type      value;
      mask_type      mask;
      mode_type      mode;
      base_reg_type  base_reg;
   } cmd_type;

   typedef struct packed {
      word_type read_data;
      logic     status;
      word_type pointer_after;
   } reply_type;

   typedef struct packed {
      cmd_type   cmd;
      logic      known;
      reply_type reply;
   } dir_entry_type;

   logic clock;
   logic reset;

   rmsr_req_if req_if ();
   rmsr_rsp_if rsp_if ();

   register_mask_save_restore #(.MEM_DEPTH(MEM_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   word_type      gen_regs [16];
   word_type      flt_regs [16];
   word_type      mem_words [MEM_DEPTH];
   bit            mem_written [MEM_DEPTH];
   reply_type     pending_replies [$];
   dir_entry_type directed [DIR_ROWS];
   int unsigned   accepted_count;
   int unsigned   fail_count;
   int unsigned   burst_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("tb_register_mask_save_restore: done, errors");
      $finish;
   end

   function automatic int unsigned transfer_word(word_type start, mode_type mode,
                                                 int unsigned k);
      word_type offs;
      word_type ptr;
      offs = PTR_STEP * (k + (mode[1] ? 1 : 0));
      ptr  = mode[0] ? start - offs : start + offs;
      return int'((ptr >> 3) % MEM_DEPTH);
   endfunction

   function automatic reply_type apply_action(cmd_type c);
      reply_type   r;
      word_type    ptr;
      int unsigned k;
      int unsigned w;
      int          i;
      r = '0;
      case (c.action)
         ACT_WRITE_REG: begin
            if (c.reg_index[4]) flt_regs[c.reg_index[3:0]] = c.value;
            else gen_regs[c.reg_index[3:0]] = c.value;
         end
         ACT_READ_REG: begin
            r.read_data = c.reg_index[4] ? flt_regs[c.reg_index[3:0]]
                                         : gen_regs[c.reg_index[3:0]];
         end
         ACT_WRITE_MEM: begin
            mem_words[c.mem_index]   = c.value;
            mem_written[c.mem_index] = 1'b1;
         end
         ACT_READ_MEM: begin
            r.read_data = mem_words[c.mem_index];
         end
         ACT_SAVE, ACT_RESTORE: begin
            if (c.mode > MODE_PRE_DEC) begin
               r.status = STATUS_BAD_MODE;
            end else begin
               ptr = gen_regs[c.base_reg];
               k = 0;
               if (c.action == ACT_SAVE) begin
                  for (i = 15; i >= 0; i--) begin
                     if (c.mask[i]) begin
                        w = transfer_word(ptr, c.mode, k);
                        mem_words[w] = gen_regs[i];
                        mem_written[w] = 1'b1;
                        k++;
                     end
                  end
                  for (i = 15; i >= 0; i--) begin
                     if (c.mask[16 + i]) begin
                        w = transfer_word(ptr, c.mode, k);
                        mem_words[w] = flt_regs[i];
                        mem_written[w] = 1'b1;
                        k++;
                     end
                  end
               end else begin
                  for (i = 0; i < 16; i++) begin
                     if (c.mask[16 + i]) begin
                        flt_regs[i] = mem_words[transfer_word(ptr, c.mode, k)];
                        k++;
                     end
                  end
                  for (i = 0; i < 16; i++) begin
                     if (c.mask[i]) begin
                        gen_regs[i] = mem_words[transfer_word(ptr, c.mode, k)];
                        k++;
                     end
                  end
               end
               ptr = c.mode[0] ? ptr - PTR_STEP * k : ptr + PTR_STEP * k;
               gen_regs[c.base_reg] = ptr;
               r.pointer_after = ptr;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Memory words that were never written must not be read, so reads of such
   // words are redirected or become writes, and unsafe restores become saves.
   function automatic cmd_type make_safe(cmd_type c);
      int unsigned probe;
      int unsigned k;
      int unsigned count;
      bit          safe;
      safe = 1'b1;
      if (c.action == ACT_READ_MEM && !mem_written[c.mem_index]) begin
         for (probe = 0; probe < 16 && !mem_written[c.mem_index]; probe++)
            c.mem_index = mem_index_type'($urandom_range(0, MEM_DEPTH - 1));
         if (!mem_written[c.mem_index]) c.action = ACT_WRITE_MEM;
      end else if (c.action == ACT_RESTORE && c.mode <= MODE_PRE_DEC) begin
         count = $countones(c.mask);
         for (k = 0; k < count; k++)
            if (!mem_written[transfer_word(gen_regs[c.base_reg], c.mode, k)]) safe = 1'b0;
         if (!safe) c.action = ACT_SAVE;
      end
      return c;
   endfunction

   function automatic dir_entry_type dir_row(action_type a, reg_index_type ri,
                                             mem_index_type mi, word_type v, mask_type mk,
                                             mode_type md, base_reg_type b, logic known,
                                             word_type rd, logic st, word_type pa);
      dir_entry_type e;
      e.cmd   = '{action: a, reg_index: ri, mem_index: mi, value: v, mask: mk, mode: md,
                  base_reg: b};
      e.known = known;
      e.reply = '{read_data: rd, status: st, pointer_after: pa};
      return e;
   endfunction

   function automatic mask_type random_mask();
      case ($urandom_range(0, 5))
         0: return mask_type'(1) << $urandom_range(0, 31);
         1: return (mask_type'(1) << $urandom_range(0, 31))
                 | (mask_type'(1) << $urandom_range(0, 31));
         2: return '1;
         3: return '0;
         4: return $urandom & 32'h0000_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type random_cmd();
      cmd_type c;
      c.action    = action_type'($urandom_range(0, 7));
      c.reg_index = reg_index_type'($urandom_range(0, 31));
      c.mem_index = mem_index_type'($urandom_range(0, MEM_DEPTH - 1));
      c.value     = {$urandom, $urandom};
      c.mask      = random_mask();
      c.mode      = mode_type'($urandom_range(0, 7));
      c.base_reg  = base_reg_type'($urandom_range(0, 15));
      return c;
   endfunction

   task automatic offer(input cmd_type c, input logic known, input reply_type typed);
      reply_type predicted;
      c = make_safe(c);
      req_if.valid     <= 1'b1;
      req_if.action    <= c.action;
      req_if.reg_index <= c.reg_index;
      req_if.mem_index <= c.mem_index;
      req_if.value     <= c.value;
      req_if.mask      <= c.mask;
      req_if.mode      <= c.mode;
      req_if.base_reg  <= c.base_reg;
      do @(posedge clock); while (!req_if.ready);
      predicted = apply_action(c);
      pending_replies.push_back(known ? typed : predicted);
      accepted_count++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 24);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      reply_type exp_reply;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response: read_data=%h status=%b pointer_after=%h",
                        rsp_if.read_data, rsp_if.status, rsp_if.pointer_after);
         end else begin
            exp_reply = pending_replies.pop_front();
            if (rsp_if.read_data !== exp_reply.read_data
                || rsp_if.status !== exp_reply.status
                || rsp_if.pointer_after !== exp_reply.pointer_after) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected rd=%h st=%b pa=%h, got rd=%h st=%b pa=%h",
                           exp_reply.read_data, exp_reply.status, exp_reply.pointer_after,
                           rsp_if.read_data, rsp_if.status, rsp_if.pointer_after);
            end
         end
      end
   end

   initial begin : receiver
      int unsigned stretch;
      int unsigned style;
      int unsigned tick;
      bit          hold_done;
      hold_done = 1'b0;
      tick = 0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && accepted_count >= HOLD_AT) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         stretch = $urandom_range(20, 80);
         style = $urandom_range(0, 2);
         repeat (stretch) begin
            case (style)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= $urandom_range(0, 1);
               default: rsp_if.ready <= (tick % 7) < 4;
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   initial begin : sender
      cmd_type      c;
      base_reg_type b;
      mode_type     m;
      mask_type     mk;
      bit           drained;
      int unsigned  i;
      int unsigned  n;
      drained = 1'b0;
      accepted_count = 0;
      fail_count = 0;
      burst_left = 8;
      for (i = 0; i < 16; i++) begin
         gen_regs[i] = '0;
         flt_regs[i] = '0;
      end
      for (i = 0; i < MEM_DEPTH; i++) begin
         mem_words[i] = '0;
         mem_written[i] = 1'b0;
      end

      directed[0]  = dir_row(ACT_READ_REG, 5'd0, 10'd0, '0, '0, MODE_POST_INC, 4'd0,
                             1'b1, '0, STATUS_OK, '0);
      directed[1]  = dir_row(ACT_READ_REG, 5'd31, 10'd0, '0, '0, MODE_POST_INC, 4'd0,
                             1'b1, '0, STATUS_OK, '0);
      directed[2]  = dir_row(ACT_WRITE_REG, 5'd0, 10'd0, ALL_ONES, '0, MODE_POST_INC, 4'd0,
                             1'b1, '0, STATUS_OK, '0);
      directed[3]  = dir_row(ACT_WRITE_REG, 5'd31, 10'd0, 64'h8000_0000_0000_0001, '0,
                             MODE_POST_INC, 4'd0, 1'b1, '0, STATUS_OK, '0);
      directed[4]  = dir_row(ACT_READ_REG, 5'd31, 10'd0, '0, '0, MODE_POST_INC, 4'd0,
                             1'b1, 64'h8000_0000_0000_0001, STATUS_OK, '0);
      directed[5]  = dir_row(ACT_READ_REG, 5'd0, 10'd0, '0, '0, MODE_POST_INC, 4'd0,
                             1'b1, ALL_ONES, STATUS_OK, '0);
      directed[6]  = dir_row(ACT_WRITE_MEM, 5'd0, 10'd0, 64'h0123_4567_89AB_CDEF, '0,
                             MODE_POST_INC, 4'd0, 1'b1, '0, STATUS_OK, '0);
      directed[7]  = dir_row(ACT_WRITE_MEM, 5'd0, 10'd1023, ALL_ONES, '0, MODE_POST_INC,
                             4'd0, 1'b1, '0, STATUS_OK, '0);
      directed[8]  = dir_row(ACT_READ_MEM, 5'd0, 10'd1023, '0, '0, MODE_POST_INC, 4'd0,
                             1'b1, ALL_ONES, STATUS_OK, '0);
      directed[9]  = dir_row(ACT_READ_MEM, 5'd0, 10'd0, '0, '0, MODE_POST_INC, 4'd0,
                             1'b1, 64'h0123_4567_89AB_CDEF, STATUS_OK, '0);
      directed[10] = dir_row(ACT_SAVE, 5'd0, 10'd0, '0, '1, MODE_BAD_LO, 4'd0,
                             1'b1, '0, STATUS_BAD_MODE, '0);
      directed[11] = dir_row(ACT_RESTORE, 5'd31, 10'd1023, ALL_ONES, '1, MODE_BAD_HI, 4'd15,
                             1'b1, '0, STATUS_BAD_MODE, '0);
      directed[12] = dir_row(ACT_UNDEF_LO, 5'd31, 10'd1023, ALL_ONES, '1, MODE_POST_INC,
                             4'd15, 1'b1, '0, STATUS_OK, '0);
      directed[13] = dir_row(ACT_UNDEF_HI, 5'd0, 10'd0, ALL_ONES, '1, MODE_BAD_HI, 4'd0,
                             1'b1, '0, STATUS_OK, '0);
      directed[14] = dir_row(ACT_WRITE_REG, 5'd2, 10'd0, 64'h2000, '0, MODE_POST_INC, 4'd0,
                             1'b1, '0, STATUS_OK, '0);
      directed[15] = dir_row(ACT_SAVE, 5'd0, 10'd0, '0, '0, MODE_PRE_DEC, 4'd2,
                             1'b1, '0, STATUS_OK, 64'h2000);
      directed[16] = dir_row(ACT_SAVE, 5'd0, 10'd0, '0, '1, MODE_PRE_DEC, 4'd2,
                             1'b0, '0, STATUS_OK, '0);
      directed[17] = dir_row(ACT_RESTORE, 5'd0, 10'd0, '0, '1, MODE_POST_INC, 4'd2,
                             1'b0, '0, STATUS_OK, '0);
      directed[18] = dir_row(ACT_READ_REG, 5'd2, 10'd0, '0, '0, MODE_POST_INC, 4'd0,
                             1'b0, '0, STATUS_OK, '0);
      directed[19] = dir_row(ACT_WRITE_REG, 5'd5, 10'd0, 64'hFFFF_FFFF_FFFF_FFF8, '0,
                             MODE_POST_INC, 4'd0, 1'b1, '0, STATUS_OK, '0);
      directed[20] = dir_row(ACT_SAVE, 5'd0, 10'd0, '0, 32'h0001_0020, MODE_PRE_INC, 4'd5,
                             1'b0, '0, STATUS_OK, '0);
      directed[21] = dir_row(ACT_RESTORE, 5'd0, 10'd0, '0, 32'h0001_0020, MODE_POST_DEC,
                             4'd5, 1'b0, '0, STATUS_OK, '0);
      directed[22] = dir_row(ACT_SAVE, 5'd0, 10'd0, '0, 32'h0000_8001, MODE_POST_INC, 4'd3,
                             1'b0, '0, STATUS_OK, '0);
      directed[23] = dir_row(ACT_RESTORE, 5'd0, 10'd0, '0, 32'h0000_8001, MODE_PRE_DEC,
                             4'd3, 1'b0, '0, STATUS_OK, '0);
      directed[24] = dir_row(ACT_SAVE, 5'd0, 10'd0, '0, 32'hA5A5_5A5A, MODE_POST_DEC, 4'd0,
                             1'b0, '0, STATUS_OK, '0);
      directed[25] = dir_row(ACT_RESTORE, 5'd0, 10'd0, '0, 32'hA5A5_5A5A, MODE_PRE_INC,
                             4'd0, 1'b0, '0, STATUS_OK, '0);
      directed[26] = dir_row(ACT_READ_MEM, 5'd0, 10'd0, '0, '0, MODE_POST_INC, 4'd0,
                             1'b0, '0, STATUS_OK, '0);

      reset <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.action    <= ACT_WRITE_REG;
      req_if.reg_index <= '0;
      req_if.mem_index <= '0;
      req_if.value     <= '0;
      req_if.mask      <= '0;
      req_if.mode      <= MODE_POST_INC;
      req_if.base_reg  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         offer(directed[i].cmd, directed[i].known, directed[i].reply);

      while (accepted_count < DIR_ROWS + RANDOM_ITEMS) begin
         if (!drained && accepted_count >= PAUSE_AT) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_replies.size() != 0);
            drained = 1'b1;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               // Stack push followed by the matching pop.
               b  = base_reg_type'($urandom_range(0, 15));
               m  = mode_type'($urandom_range(0, 3));
               mk = random_mask();
               c  = random_cmd();
               if ($urandom_range(0, 3) != 0) begin
                  c.action    = ACT_WRITE_REG;
                  c.reg_index = {1'b0, b};
                  case ($urandom_range(0, 3))
                     0: c.value = {$urandom, $urandom};
                     1: c.value = 64'($urandom_range(0, 8191));
                     2: c.value = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 255));
                     default: c.value = 64'($urandom_range(0, 255));
                  endcase
                  offer(c, 1'b0, '0);
               end
               n = $urandom_range(0, 3);
               repeat (n) begin
                  c = random_cmd();
                  c.action = ACT_WRITE_REG;
                  offer(c, 1'b0, '0);
               end
               c = random_cmd();
               c.action = ACT_SAVE;
               c.mask = mk;
               c.mode = m;
               c.base_reg = b;
               offer(c, 1'b0, '0);
               n = $urandom_range(0, 3);
               repeat (n) begin
                  c = random_cmd();
                  c.action = action_type'($urandom_range(0, 3));
                  if (c.action == ACT_WRITE_REG && c.reg_index == {1'b0, b})
                     c.action = ACT_READ_REG;
                  offer(c, 1'b0, '0);
               end
               c = random_cmd();
               c.action = ACT_RESTORE;
               c.mask = mk;
               c.mode = MODE_PRE_DEC - m;
               c.base_reg = b;
               offer(c, 1'b0, '0);
               n = $urandom_range(0, 2);
               repeat (n) begin
                  c = random_cmd();
                  c.action = ACT_READ_REG;
                  offer(c, 1'b0, '0);
               end
            end
            11, 12, 13, 14: begin
               c = random_cmd();
               c.action = action_type'($urandom_range(0, 3));
               offer(c, 1'b0, '0);
            end
            15: begin
               c = random_cmd();
               c.action = ($urandom_range(0, 1) != 0) ? ACT_SAVE : ACT_RESTORE;
               c.mode = mode_type'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
               offer(c, 1'b0, '0);
            end
            16: begin
               c = random_cmd();
               c.action = action_type'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
               offer(c, 1'b0, '0);
            end
            default: begin
               c = random_cmd();
               if ($urandom_range(0, 1) != 0) begin
                  c.action = ($urandom_range(0, 1) != 0) ? ACT_SAVE : ACT_RESTORE;
                  c.mode = mode_type'($urandom_range(0, 3));
               end
               offer(c, 1'b0, '0);
            end
         endcase
      end

      req_if.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_replies.size() == 0)
         $display("tb_register_mask_save_restore: done, clean");
      else
         $display("tb_register_mask_save_restore: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rmsr_pkg.sv
rtl/rmsr_req_if.sv
rtl/rmsr_rsp_if.sv
rtl/rmsr_ram.sv
rtl/register_mask_save_restore.sv
rtl/rmsr_checker.sv
sim/tb_register_mask_save_restore.sv
